>>> hw/rtl/bca_pkg.sv
package bca_pkg;

  // Store geometry
  localparam int unsigned NUM_BINS   = 4096;
  localparam int unsigned TOTAL_BITS = 40;
  localparam int unsigned BIN_AW     = $clog2(NUM_BINS);
  localparam int unsigned USED_W     = BIN_AW + 1;

  // Request operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FILTERED = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUAL  = 1'd1;
  localparam logic [15:0] BIN_WIDTH_RST = 16'd1000;
  localparam logic [7:0]  MIN_QUAL_RST  = 8'd4;

  // Start divider: quotient bits retired per cycle
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STEPS  = 32 / DIV_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic stat_upd;
    logic stat_clr;
    logic div_start;
    logic walk_init;
    logic bin_rd;
    logic bin_wr;
    logic idx_rd;
    logic clr_wr;
    logic resp_load;
  } bca_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       filtered;
    logic       span_zero;
    logic       div_done;
    logic       first_beyond;
    logic       walk_last;
    logic       clr_last;
    logic       out_free;
  } bca_sts_t;

endpackage

>>> hw/rtl/bca_req_if.sv
interface bca_req_if import bca_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] align_start;
  logic [15:0] align_span;
  logic [7:0]  map_quality;
  logic [11:0] bin_index;

  modport source (
    output valid, operation, align_start, align_span, map_quality, bin_index,
    input  ready
  );
  modport sink (
    input  valid, operation, align_start, align_span, map_quality, bin_index,
    output ready
  );
endinterface

>>> hw/rtl/bca_rsp_if.sv
interface bca_rsp_if import bca_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [39:0] bin_total;
  logic [12:0] bins_used;
  logic [31:0] aligns_counted;
  logic [31:0] least_start;
  logic [31:0] greatest_end;
  logic [15:0] widest_span;
  logic [1:0]  status;

  modport source (
    output valid, bin_total, bins_used, aligns_counted, least_start, greatest_end,
           widest_span, status,
    input  ready
  );
  modport sink (
    input  valid, bin_total, bins_used, aligns_counted, least_start, greatest_end,
           widest_span, status,
    output ready
  );
endinterface

>>> hw/rtl/bca_cfg_if.sv
interface bca_cfg_if import bca_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

>>> hw/rtl/bca_divider.sv
module bca_divider import bca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic [31:0] quot_o,
  output logic [15:0] rem_o,
  output logic        done_o
);

  logic [31:0]          quot_q;
  logic [15:0]          rem_q;
  logic [15:0]          dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [31:0]          quot_d;
  logic [15:0]          rem_d;

  // Retire several restoring-division steps per cycle
  always_comb begin
    logic [16:0] part;
    part   = '0;
    quot_d = quot_q;
    rem_d  = rem_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      part   = {rem_d, quot_d[31]};
      quot_d = {quot_d[30:0], 1'b0};
      if (part >= {1'b0, dvs_q}) begin
        part      = part - {1'b0, dvs_q};
        quot_d[0] = 1'b1;
      end
      rem_d = part[15:0];
    end
  end

  // Hold control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Advance the quotient and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

>>> hw/rtl/bca_datapath.sv
module bca_datapath import bca_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bca_cmd_t    cmd_i,
  output bca_sts_t    sts_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] align_start_i,
  input  logic [15:0] align_span_i,
  input  logic [7:0]  map_quality_i,
  input  logic [11:0] bin_index_i,
  input  logic [15:0] bin_width_i,
  input  logic [7:0]  min_quality_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [39:0] bin_total_o,
  output logic [12:0] bins_used_o,
  output logic [31:0] aligns_counted_o,
  output logic [31:0] least_start_o,
  output logic [31:0] greatest_end_o,
  output logic [15:0] widest_span_o,
  output logic [1:0]  status_o
);

  localparam int unsigned SUM_W = TOTAL_BITS + 1;

  // Captured request
  logic [1:0]  op_q;
  logic [31:0] start_q;
  logic [15:0] span_q;
  logic [7:0]  qual_q;
  logic [11:0] idx_q;

  // Running statistics
  logic [USED_W-1:0] used_q;
  logic [31:0]       count_q;
  logic [31:0]       min_start_q;
  logic [31:0]       max_end_q;
  logic [15:0]       max_span_q;

  // Bin walk
  logic [BIN_AW-1:0] bin_q;
  logic [32:0]       lo_q;
  logic [15:0]       amt_q;
  logic              last_q;
  logic              beyond_q;
  logic              drop_q;
  logic [BIN_AW-1:0] clr_cnt_q;

  // Bin store
  logic [TOTAL_BITS-1:0] mem [NUM_BINS];
  logic [TOTAL_BITS-1:0] rdata_q;

  // Result register
  logic        out_valid_q;
  logic [39:0] total_q;
  logic [12:0] used_out_q;
  logic [31:0] count_out_q;
  logic [31:0] min_out_q;
  logic [31:0] max_end_out_q;
  logic [15:0] span_out_q;
  logic [1:0]  status_q;

  logic [15:0]           width_eff;
  logic [32:0]           end_w;
  logic [31:0]           end32_w;
  logic [32:0]           hi_w;
  logic [32:0]           s_w;
  logic [32:0]           e_w;
  logic                  filtered;
  logic                  idx_oob;
  logic                  bin_top;
  logic [31:0]           quot;
  logic [15:0]           rem;
  logic                  div_done;
  logic                  first_beyond;
  logic [SUM_W-1:0]      sum_w;
  logic [TOTAL_BITS-1:0] sat_w;
  logic [USED_W-1:0]     cand_w;
  logic                  wr_en;
  logic [BIN_AW-1:0]     wr_addr;
  logic [TOTAL_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [BIN_AW-1:0]     rd_addr;
  logic [1:0]            status_w;
  logic [TOTAL_BITS-1:0] total_w;

  // Decode the captured request
  assign width_eff = (bin_width_i == '0) ? 16'd1 : bin_width_i;
  assign end_w     = {1'b0, start_q} + {17'b0, span_q};
  assign end32_w   = end_w[32] ? '1 : end_w[31:0];
  assign filtered  = (min_quality_i != '0) && (qual_q < min_quality_i);
  assign idx_oob   = {20'b0, idx_q} >= NUM_BINS;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      start_q <= align_start_i;
      span_q  <= align_span_i;
      qual_q  <= map_quality_i;
      idx_q   <= bin_index_i;
    end
  end

  bca_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (start_q),
    .divisor_i  (width_eff),
    .quot_o     (quot),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  assign first_beyond = quot >= NUM_BINS;

  // Overlap of the current bin with the alignment
  assign hi_w    = lo_q + {17'b0, width_eff};
  assign s_w     = ({1'b0, start_q} > lo_q) ? {1'b0, start_q} : lo_q;
  assign e_w     = (end_w < hi_w) ? end_w : hi_w;
  assign bin_top = bin_q == BIN_AW'(NUM_BINS - 1);
  assign cand_w  = beyond_q ? USED_W'(NUM_BINS) : ({1'b0, bin_q} + 1'b1);

  // Step through the overlapped bins
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      bin_q <= BIN_AW'(quot);
      lo_q  <= {1'b0, start_q - {16'b0, rem}};
    end else if (cmd_i.bin_wr && !last_q) begin
      bin_q <= bin_q + 1'b1;
      lo_q  <= hi_w;
    end
    if (cmd_i.bin_rd) begin
      amt_q    <= 16'(e_w - s_w);
      last_q   <= (hi_w >= end_w) || bin_top;
      beyond_q <= (hi_w < end_w) && bin_top;
    end
  end

  // Track dropped bins for the status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= 1'b0;
    end else if (cmd_i.load) begin
      drop_q <= 1'b0;
    end else if (cmd_i.walk_init && first_beyond) begin
      drop_q <= 1'b1;
    end else if (cmd_i.bin_wr && last_q && beyond_q) begin
      drop_q <= 1'b1;
    end
  end

  // Update the running statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      count_q     <= '0;
      min_start_q <= '1;
      max_end_q   <= '0;
      max_span_q  <= '0;
    end else if (cmd_i.stat_clr) begin
      used_q      <= '0;
      count_q     <= '0;
      min_start_q <= '1;
      max_end_q   <= '0;
      max_span_q  <= '0;
    end else begin
      if (cmd_i.stat_upd) begin
        if (count_q != '1) begin
          count_q <= count_q + 1'b1;
        end
        if (span_q != '0) begin
          if (span_q > max_span_q) begin
            max_span_q <= span_q;
          end
          if (start_q < min_start_q) begin
            min_start_q <= start_q;
          end
          if (end32_w > max_end_q) begin
            max_end_q <= end32_w;
          end
        end
      end
      if (cmd_i.walk_init && first_beyond) begin
        used_q <= USED_W'(NUM_BINS);
      end else if (cmd_i.bin_wr && last_q && (cand_w > used_q)) begin
        used_q <= cand_w;
      end
    end
  end

  // Sweep counter for clearing the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      if (clr_cnt_q == BIN_AW'(NUM_BINS - 1)) begin
        clr_cnt_q <= '0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // Saturating add into the bin
  assign sum_w = {1'b0, rdata_q} + SUM_W'(amt_q);
  assign sat_w = sum_w[TOTAL_BITS] ? '1 : sum_w[TOTAL_BITS-1:0];

  assign wr_en   = cmd_i.clr_wr || cmd_i.bin_wr;
  assign wr_addr = cmd_i.clr_wr ? clr_cnt_q : bin_q;
  assign wr_data = cmd_i.clr_wr ? '0 : sat_w;
  assign rd_en   = cmd_i.bin_rd || cmd_i.idx_rd;
  assign rd_addr = cmd_i.idx_rd ? BIN_AW'(idx_q) : bin_q;

  // Bin store write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Bin store read port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Assemble the result
  always_comb begin
    status_w = ST_OK;
    total_w  = '0;
    case (op_q)
      OP_ADD: begin
        if (filtered) begin
          status_w = ST_FILTERED;
        end else if (drop_q) begin
          status_w = ST_DROPPED;
        end
      end
      OP_READ: begin
        if (idx_oob) begin
          status_w = ST_DROPPED;
        end else begin
          total_w = rdata_q;
        end
      end
      default: begin
        status_w = ST_OK;
      end
    endcase
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_load) begin
      total_q       <= 40'(total_w);
      used_out_q    <= 13'(used_q);
      count_out_q   <= count_q;
      min_out_q     <= min_start_q;
      max_end_out_q <= max_end_q;
      span_out_q    <= max_span_q;
      status_q      <= status_w;
    end
  end

  assign sts_o.op           = op_q;
  assign sts_o.filtered     = filtered;
  assign sts_o.span_zero    = span_q == '0;
  assign sts_o.div_done     = div_done;
  assign sts_o.first_beyond = first_beyond;
  assign sts_o.walk_last    = last_q;
  assign sts_o.clr_last     = clr_cnt_q == BIN_AW'(NUM_BINS - 1);
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign bin_total_o      = total_q;
  assign bins_used_o      = used_out_q;
  assign aligns_counted_o = count_out_q;
  assign least_start_o    = min_out_q;
  assign greatest_end_o   = max_end_out_q;
  assign widest_span_o    = span_out_q;
  assign status_o         = status_q;

endmodule

>>> hw/rtl/bca_ctrl.sv
module bca_ctrl import bca_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bca_sts_t sts_i,
  output bca_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_BOOT_CLR,
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_BIN_RD,
    S_BIN_WR,
    S_ITEM_CLR,
    S_RESP
  } state_e;

  state_e state_q;
  state_e state_d;

  // Sequence one request at a time
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_BOOT_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        case (sts_i.op)
          OP_ADD: begin
            if (sts_i.filtered) begin
              state_d = S_RESP;
            end else begin
              cmd_o.stat_upd = 1'b1;
              if (sts_i.span_zero) begin
                state_d = S_RESP;
              end else begin
                cmd_o.div_start = 1'b1;
                state_d         = S_DIV;
              end
            end
          end
          OP_READ: begin
            cmd_o.idx_rd = 1'b1;
            state_d      = S_RESP;
          end
          OP_CLEAR: begin
            cmd_o.stat_clr = 1'b1;
            state_d        = S_ITEM_CLR;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.walk_init = 1'b1;
          state_d = sts_i.first_beyond ? S_RESP : S_BIN_RD;
        end
      end
      S_BIN_RD: begin
        cmd_o.bin_rd = 1'b1;
        state_d      = S_BIN_WR;
      end
      S_BIN_WR: begin
        cmd_o.bin_wr = 1'b1;
        state_d = sts_i.walk_last ? S_RESP : S_BIN_RD;
      end
      S_ITEM_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/binned_coverage_accumulator_unit.sv
// Binned alignment coverage accumulator.
// req_i takes one request at a time: add an alignment, read one bin, or
// clear the store and statistics. rsp_o returns exactly one result per
// request, carrying the bin total (read only), the running statistics as
// they stand after the request, and a status code. cfg_i writes the bin
// width and the quality threshold; write it only while no request is open.
// A read, a filtered add or an empty add goes straight to the result. A
// nonempty add first runs the start divider (4 quotient bits per cycle),
// then does a read-modify-write of the bin memory for each bin it
// overlaps. A clear sweeps all NUM_BINS bins of the store to zero.
// req_i is ready again in the cycle after the result is loaded.
// After reset the bin memory is likewise swept to zero, all NUM_BINS bins
// (4096 by default); req_i stays not ready meanwhile, cfg_i is taken.
// The result sits in an output register: a new request is accepted while
// the previous result waits, and the block holds its last step until the
// receiver takes the pending result.
module binned_coverage_accumulator_unit import bca_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  bca_req_if.sink   req_i,
  bca_rsp_if.source rsp_o,
  bca_cfg_if.sink   cfg_i
);

  logic [15:0] bin_width_q;
  logic [7:0]  min_qual_q;
  bca_cmd_t    cmd;
  bca_sts_t    sts;

  // Take configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= BIN_WIDTH_RST;
      min_qual_q  <= MIN_QUAL_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BIN_WIDTH: bin_width_q <= cfg_i.data;
        CFG_MIN_QUAL:  min_qual_q  <= cfg_i.data[7:0];
        default: begin
          bin_width_q <= bin_width_q;
        end
      endcase
    end
  end

  bca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bca_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (req_i.operation),
    .align_start_i    (req_i.align_start),
    .align_span_i     (req_i.align_span),
    .map_quality_i    (req_i.map_quality),
    .bin_index_i      (req_i.bin_index),
    .bin_width_i      (bin_width_q),
    .min_quality_i    (min_qual_q),
    .out_ready_i      (rsp_o.ready),
    .out_valid_o      (rsp_o.valid),
    .bin_total_o      (rsp_o.bin_total),
    .bins_used_o      (rsp_o.bins_used),
    .aligns_counted_o (rsp_o.aligns_counted),
    .least_start_o    (rsp_o.least_start),
    .greatest_end_o   (rsp_o.greatest_end),
    .widest_span_o    (rsp_o.widest_span),
    .status_o         (rsp_o.status)
  );

endmodule
